@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define TGNI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define TGNI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/tgni_pkg.sv @@
// Shared types, constants and offset tables of the tetrahedral grid neighbor iterator.
// Used by all modules of the block; depends on nothing.
`default_nettype none
package tgni_pkg;

	localparam int VTX_W       = 25;
	localparam int DEG_W       = 18;
	localparam int SIZE_W      = 9;
	localparam int CRD_W       = 10;
	localparam int TI_W        = 5;
	localparam int DIV_CNT_W   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int DEF_MAX_DIM = 256;
	localparam int MIN_DIM     = 3;
	localparam int DEG_REGULAR = 18;

	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_SIZE = 2'd0,
		CFG_Y_SIZE = 2'd1,
		CFG_Z_SIZE = 2'd2,
		CFG_BASE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_BELOW    = 3'd0,
		PH_LEVEL    = 3'd1,
		PH_ABOVE    = 3'd2,
		PH_BLAST    = 3'd3,
		PH_CLQ_PREP = 3'd4,
		PH_CLQ_PRE  = 3'd5,
		PH_CLQ_POST = 3'd6,
		PH_DONE     = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		DEG_ZERO  = 2'd0,
		DEG_REG   = 2'd1,
		DEG_LAST  = 2'd2,
		DEG_BLAST = 2'd3
	} deg_sel_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_CLASS = 7'b0000100,
		ST_STEP  = 7'b0001000,
		ST_MUL1  = 7'b0010000,
		ST_MUL2  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} ctl_state_t;

	typedef struct packed {
		logic               opcode;
		logic [VTX_W-1:0]   vertex;
	} req_t;

	typedef struct packed {
		logic [VTX_W-1:0]   neighbor;
		logic               done_res;
		logic [DEG_W-1:0]   degree_bound;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic div_step;
		logic classify;
		logic adv_step;
		logic mul1;
		logic mul2;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_next;
		logic start_bad;
		logic div_last;
		logic div_second;
		logic class_bad;
		logic adv_found;
		logic adv_done;
		logic rsp_free;
	} sts_t;

	// X offsets of the neighbor table.
	function automatic logic signed [1:0] off_dx(input logic [TI_W-1:0] ti);
		logic signed [1:0] d;
		case (ti)
			5'd3, 5'd7, 5'd9, 5'd12, 5'd16:         d = 2'sb01;
			5'd4, 5'd5, 5'd8, 5'd10, 5'd14:         d = 2'sb11;
			default:                                d = 2'sb00;
		endcase
		return d;
	endfunction

	// Y offsets of the neighbor table.
	function automatic logic signed [1:0] off_dy(input logic [TI_W-1:0] ti);
		logic signed [1:0] d;
		case (ti)
			5'd1, 5'd10, 5'd11, 5'd12, 5'd17:       d = 2'sb01;
			5'd2, 5'd5, 5'd6, 5'd7, 5'd13:          d = 2'sb11;
			default:                                d = 2'sb00;
		endcase
		return d;
	endfunction

	// End of the table group that belongs to a phase.
	function automatic logic [TI_W-1:0] table_limit(input phase_t ph);
		logic [TI_W-1:0] l;
		case (ph)
			PH_LEVEL: l = 5'd13;
			PH_ABOVE: l = 5'd18;
			default:  l = 5'd5;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

@@ src/tgni_ctrl.sv @@
// Controller state machine of the neighbor iterator.
// Depends on tgni_pkg for the state, command and status types.
`default_nettype none
module tgni_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire tgni_pkg::sts_t sts,
	output tgni_pkg::cmd_t     cmd
);

	tgni_pkg::ctl_state_t state_q, state_n;

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			tgni_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					if (sts.req_next) state_n = tgni_pkg::ST_STEP;
					else if (sts.start_bad) state_n = tgni_pkg::ST_EMIT;
					else state_n = tgni_pkg::ST_DIV;
				end
			end
			tgni_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last && sts.div_second) state_n = tgni_pkg::ST_CLASS;
			end
			tgni_pkg::ST_CLASS: begin
				cmd.classify = 1'b1;
				state_n = sts.class_bad ? tgni_pkg::ST_EMIT : tgni_pkg::ST_STEP;
			end
			tgni_pkg::ST_STEP: begin
				cmd.adv_step = 1'b1;
				if (sts.adv_found) state_n = tgni_pkg::ST_MUL1;
				else if (sts.adv_done) state_n = tgni_pkg::ST_EMIT;
			end
			tgni_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n = tgni_pkg::ST_MUL2;
			end
			tgni_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n = tgni_pkg::ST_EMIT;
			end
			tgni_pkg::ST_EMIT: begin
				if (sts.rsp_free) begin
					cmd.emit = 1'b1;
					state_n = tgni_pkg::ST_IDLE;
				end
			end
			default: state_n = tgni_pkg::ST_IDLE;
		endcase
	end

	assign req_ready = (state_q == tgni_pkg::ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgni_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
`default_nettype wire

@@ src/tgni_datapath.sv @@
// Datapath of the neighbor iterator: size registers, divider, table walk,
// clique raster, address multiply-add and the response register.
// Depends on tgni_pkg.
`default_nettype none
module tgni_datapath #(
	parameter int MAX_DIM = tgni_pkg::DEF_MAX_DIM
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tgni_pkg::req_t                req,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tgni_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tgni_pkg::SIZE_W-1:0]    cfg_data,
	input  wire tgni_pkg::cmd_t                cmd,
	output tgni_pkg::sts_t                     sts,
	output tgni_pkg::rsp_t                     rsp,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready
);

	localparam int SW = tgni_pkg::SIZE_W;
	localparam int CW = tgni_pkg::CRD_W;
	localparam int VW = tgni_pkg::VTX_W;
	localparam int TW = tgni_pkg::TI_W;
	localparam int DW = tgni_pkg::DEG_W;
	localparam int NC = tgni_pkg::DIV_CNT_W;
	localparam logic [NC-1:0] DIV_LAST = NC'(VW - 1);

	// Clamp a size register to the supported range.
	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] r);
		logic [SW-1:0] e;
		if (r < SW'(tgni_pkg::MIN_DIM)) e = SW'(tgni_pkg::MIN_DIM);
		else if (32'(r) > MAX_DIM) e = SW'(MAX_DIM);
		else e = r;
		return e;
	endfunction

	logic [SW-1:0] x_size_q, y_size_q, z_size_q;
	logic          base_q;
	logic [SW-1:0] xs, ys, zs;

	logic [SW-1:0] cen_x_q, cen_y_q, cen_z_q;
	tgni_pkg::phase_t phase_q, ph_n;
	logic [TW-1:0] ti_q, ti_n;
	logic [CW-1:0] scan_x_q, scan_y_q, scan_z_q, sx_n, sy_n, sz_n;

	logic [VW-1:0] num_q;
	logic [SW-1:0] rem_q;
	logic [NC-1:0] div_cnt_q;
	logic          div_second_q;

	logic [SW-1:0]    nx_q, ny_q;
	logic [CW-1:0]    nz_q;
	logic [19:0]      p1_q;
	logic [VW-1:0]    neigh_q;
	logic [DW-1:0]    xy_q;
	tgni_pkg::deg_sel_t deg_sel_q;
	logic             res_done_q;

	assign xs = eff_size(x_size_q);
	assign ys = eff_size(y_size_q);
	assign zs = eff_size(z_size_q);
	assign cfg_ready = 1'b1;

	// One restoring division step.
	logic [SW:0]   rem_sh, rem_sub, divisor;
	logic          div_ge;
	logic [SW-1:0] rem_n;
	logic [VW-1:0] num_n;
	assign divisor = {1'b0, div_second_q ? ys : xs};
	assign rem_sh  = {rem_q, num_q[VW-1]};
	assign div_ge  = rem_sh >= divisor;
	assign rem_sub = rem_sh - divisor;
	assign rem_n   = div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
	assign num_n   = {num_q[VW-2:0], div_ge};

	// Start checks and layer classification.
	logic start_bad, class_bad;
	assign start_bad = (req.vertex == '0) && base_q;
	assign class_bad = num_q >= VW'(zs);

	// Table walk: candidate position of the next table entry.
	logic [TW-1:0]        ti_inc;
	logic signed [1:0]    dx, dy;
	logic signed [SW+1:0] cx, cy;
	logic                 x_ok, y_ok, tbl_phase;
	assign ti_inc = ti_q + 1'b1;
	assign dx = tgni_pkg::off_dx(ti_inc);
	assign dy = tgni_pkg::off_dy(ti_inc);
	assign cx = $signed({2'b00, cen_x_q}) + {{SW{dx[1]}}, dx};
	assign cy = $signed({2'b00, cen_y_q}) + {{SW{dy[1]}}, dy};
	assign x_ok = !cx[SW+1] && (cx[SW:0] < {1'b0, xs});
	assign y_ok = !cy[SW+1] && (cy[SW:0] < {1'b0, ys});
	assign tbl_phase = (phase_q == tgni_pkg::PH_BELOW) || (phase_q == tgni_pkg::PH_LEVEL) ||
		(phase_q == tgni_pkg::PH_ABOVE) || (phase_q == tgni_pkg::PH_BLAST);

	// Clique raster: next scan position.
	logic [CW-1:0] rx, ry, rz;
	always_comb begin
		rx = scan_x_q + 1'b1;
		ry = scan_y_q;
		rz = scan_z_q;
		if (rx >= CW'(xs)) begin
			rx = '0;
			ry = scan_y_q + 1'b1;
			if (ry >= CW'(ys)) begin
				ry = '0;
				rz = scan_z_q + 1'b1;
			end
		end
	end

	// One advance step of the enumeration.
	logic          found, fin;
	logic [SW-1:0] fx, fy;
	logic [CW-1:0] fz;
	always_comb begin
		ph_n = phase_q;
		ti_n = ti_q;
		sx_n = scan_x_q;
		sy_n = scan_y_q;
		sz_n = scan_z_q;
		found = 1'b0;
		fin = 1'b0;
		fx = cx[SW-1:0];
		fy = cy[SW-1:0];
		fz = CW'(cen_z_q);
		if (tbl_phase) begin
			ti_n = ti_inc;
			if (phase_q == tgni_pkg::PH_ABOVE) fz = CW'(cen_z_q) + 1'b1;
			else if (phase_q != tgni_pkg::PH_LEVEL) fz = CW'(cen_z_q) - 1'b1;
			if (ti_inc >= tgni_pkg::table_limit(phase_q)) begin
				case (phase_q)
					tgni_pkg::PH_BELOW: ph_n = tgni_pkg::PH_LEVEL;
					tgni_pkg::PH_LEVEL: ph_n = tgni_pkg::PH_ABOVE;
					tgni_pkg::PH_BLAST: ph_n = tgni_pkg::PH_CLQ_PREP;
					default: begin
						ph_n = tgni_pkg::PH_DONE;
						fin = 1'b1;
					end
				endcase
			end else if (x_ok && y_ok) begin
				found = 1'b1;
			end
		end else if (phase_q == tgni_pkg::PH_CLQ_PREP) begin
			ph_n = tgni_pkg::PH_CLQ_PRE;
			sx_n = CW'(xs) - 1'b1;
			sy_n = CW'(ys) - 1'b1;
			sz_n = CW'(zs) - CW'(3);
		end else if ((phase_q == tgni_pkg::PH_CLQ_PRE) ||
				(phase_q == tgni_pkg::PH_CLQ_POST)) begin
			sx_n = rx;
			sy_n = ry;
			sz_n = rz;
			fx = rx[SW-1:0];
			fy = ry[SW-1:0];
			fz = rz;
			if (rz >= CW'(zs)) begin
				ph_n = tgni_pkg::PH_DONE;
				fin = 1'b1;
			end else if ((phase_q == tgni_pkg::PH_CLQ_POST) || (rx != CW'(cen_x_q)) ||
					(ry != CW'(cen_y_q)) || (rz != CW'(cen_z_q))) begin
				found = 1'b1;
			end else begin
				ph_n = tgni_pkg::PH_CLQ_POST;
			end
		end else begin
			ph_n = tgni_pkg::PH_DONE;
			fin = 1'b1;
		end
	end

	// Status toward the controller.
	assign sts.req_next   = (req.opcode == tgni_pkg::OP_NEXT);
	assign sts.start_bad  = start_bad;
	assign sts.div_last   = (div_cnt_q == DIV_LAST);
	assign sts.div_second = div_second_q;
	assign sts.class_bad  = class_bad;
	assign sts.adv_found  = found;
	assign sts.adv_done   = fin;
	assign sts.rsp_free   = !rsp_valid || rsp_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= SW'(tgni_pkg::MIN_DIM);
			y_size_q <= SW'(tgni_pkg::MIN_DIM);
			z_size_q <= SW'(tgni_pkg::MIN_DIM);
			base_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tgni_pkg::CFG_X_SIZE: x_size_q <= cfg_data;
				tgni_pkg::CFG_Y_SIZE: y_size_q <= cfg_data;
				tgni_pkg::CFG_Z_SIZE: z_size_q <= cfg_data;
				tgni_pkg::CFG_BASE:   base_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Enumeration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_x_q      <= '0;
			cen_y_q      <= '0;
			cen_z_q      <= '0;
			phase_q      <= tgni_pkg::PH_DONE;
			ti_q         <= '1;
			scan_x_q     <= '0;
			scan_y_q     <= '0;
			scan_z_q     <= '0;
			div_cnt_q    <= '0;
			div_second_q <= 1'b0;
			deg_sel_q    <= tgni_pkg::DEG_ZERO;
			res_done_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				div_cnt_q    <= '0;
				div_second_q <= 1'b0;
				deg_sel_q    <= tgni_pkg::DEG_ZERO;
				if (req.opcode == tgni_pkg::OP_START && start_bad) begin
					phase_q    <= tgni_pkg::PH_DONE;
					res_done_q <= 1'b1;
				end
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					div_cnt_q    <= '0;
					div_second_q <= 1'b1;
					if (div_second_q) cen_y_q <= rem_n;
					else cen_x_q <= rem_n;
				end
			end
			if (cmd.classify) begin
				if (class_bad) begin
					phase_q    <= tgni_pkg::PH_DONE;
					res_done_q <= 1'b1;
				end else begin
					cen_z_q <= num_q[SW-1:0];
					if (num_q[SW-1:0] == zs - 1'b1) begin
						phase_q   <= tgni_pkg::PH_CLQ_PREP;
						deg_sel_q <= tgni_pkg::DEG_LAST;
					end else if (num_q[SW-1:0] == zs - SW'(2)) begin
						phase_q   <= tgni_pkg::PH_BLAST;
						ti_q      <= '1;
						deg_sel_q <= tgni_pkg::DEG_BLAST;
					end else if (num_q[SW-1:0] == '0) begin
						phase_q   <= tgni_pkg::PH_LEVEL;
						ti_q      <= TW'(4);
						deg_sel_q <= tgni_pkg::DEG_REG;
					end else begin
						phase_q   <= tgni_pkg::PH_BELOW;
						ti_q      <= '1;
						deg_sel_q <= tgni_pkg::DEG_REG;
					end
				end
			end
			if (cmd.adv_step) begin
				phase_q  <= ph_n;
				ti_q     <= ti_n;
				scan_x_q <= sx_n;
				scan_y_q <= sy_n;
				scan_z_q <= sz_n;
				if (found) res_done_q <= 1'b0;
				else if (fin) res_done_q <= 1'b1;
			end
		end
	end

	// Dividend, remainder and address payload.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= req.vertex - VW'(base_q);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= num_n;
			rem_q <= (div_cnt_q == DIV_LAST) ? '0 : rem_n;
		end
		if (cmd.classify) xy_q <= DW'(xs * ys);
		if (cmd.adv_step && found) begin
			nx_q <= fx;
			ny_q <= fy;
			nz_q <= fz;
		end
		if (cmd.mul1) p1_q <= 20'(nz_q * ys) + 20'(ny_q);
		if (cmd.mul2) neigh_q <= VW'(30'(p1_q * xs) + 30'(nx_q) + 30'(base_q));
	end

	// Response register.
	logic [DW:0] deg_sum;
	always_comb begin
		case (deg_sel_q)
			tgni_pkg::DEG_REG:   deg_sum = (DW+1)'(tgni_pkg::DEG_REGULAR);
			tgni_pkg::DEG_LAST:  deg_sum = {xy_q, 1'b0} - 1'b1;
			tgni_pkg::DEG_BLAST: deg_sum = {xy_q, 1'b0} + (DW+1)'(4);
			default:             deg_sum = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp.neighbor     <= res_done_q ? '0 : neigh_q;
			rsp.done_res     <= res_done_q;
			rsp.degree_bound <= deg_sum[DW-1:0];
		end
	end

endmodule
`default_nettype wire

@@ src/tetra_grid_neighbor_iterator.sv @@
// Top level of the tetrahedral grid neighbor iterator.
// Depends on tgni_pkg, tgni_ctrl and tgni_datapath.
//
// Usage:
//   req (opcode, vertex) is taken on req_valid && req_ready. A start request
//   (opcode 0) splits the vertex number into x, y, z and returns the first
//   neighbor with a degree bound; a next request (opcode 1) returns the
//   following neighbor, or done_res = 1 when the list is exhausted.
//   rsp carries one response per request on rsp_valid / rsp_ready.
//   cfg_index / cfg_data write x_size, y_size, z_size and base_value; the
//   port is always ready. The user must keep it written only while no request
//   is open; the block itself does not enforce this.
// Sequence:
//   One request is in flight at a time. A valid start runs two bit-serial
//   divisions, a classify step, table or raster steps, the multiply-add steps
//   and the emit step. A start outside the grid ends after the classify step,
//   one below the base goes straight to emit. A next request runs table or
//   raster steps, the multiply-adds and emit; at list end it skips the adds.
// Reset and stall:
//   Reset sets the sizes to their minimum and leaves the iterator in the done
//   state. A response waits in the output register while rsp_ready is low;
//   the next request is taken meanwhile and held at its end until it drains.
`default_nettype none
module tetra_grid_neighbor_iterator #(
	parameter int MAX_DIM = tgni_pkg::DEF_MAX_DIM
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire tgni_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output tgni_pkg::rsp_t                      rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tgni_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tgni_pkg::SIZE_W-1:0]    cfg_data
);

	tgni_pkg::cmd_t cmd;
	tgni_pkg::sts_t sts;

	// Sequencer.
	tgni_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	tgni_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule
`default_nettype wire

@@ src/tgni_checker.sv @@
// Port-level checks of the neighbor iterator, bound to its top level.
// Depends on tgni_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tgni_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	input  wire logic                           req_ready,
	input  wire tgni_pkg::req_t                 req,
	input  wire logic                           rsp_valid,
	input  wire logic                           rsp_ready,
	input  wire tgni_pkg::rsp_t                 rsp,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [tgni_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tgni_pkg::SIZE_W-1:0]    cfg_data
);

	// A finished list never carries a neighbor number.
	`TGNI_ASSERT_IMP(a_done_zero, rsp_valid && rsp.done_res, rsp.neighbor == '0, "done with neighbor")
	// Only one request is worked on at a time.
	`TGNI_ASSERT_NXT(a_one_open, req_valid && req_ready, !req_ready, "second request taken")
	// Ready drops only because a request was taken.
	`TGNI_ASSERT_IMP(a_ready_fall, $fell(req_ready), $past(req_valid), "ready fell without request")
	// A stalled response stays put.
	`TGNI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response lost")

endmodule

bind tetra_grid_neighbor_iterator tgni_checker u_tgni_checker (.*);
`default_nettype wire
